[sv/ssla_pkg.sv]
// Shared types and constants for the stub slot lookup-or-allocate block.
// Depends on nothing; ssla_if, ssla_seq and the top level import it.
`default_nettype none

package ssla_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int LIB_BITS    = 16;
    localparam int KEY_W       = 32;
    localparam int LIB_IN_W    = 16;
    localparam int FN_W        = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 11;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ENTRY_W     = KEY_W + LIB_BITS + FN_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED = 2'd0,
        ST_NEW    = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic [IDX_W-1:0]   rd_addr;
    } t_ram_cmd;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [IDX_W-1:0] index;
    } t_result;

endpackage

`default_nettype wire

[sv/ssla_if.sv]
// Request and response channel interfaces of the stub slot table.
// Depends on ssla_pkg for the field widths.
`default_nettype none

interface ssla_req_if import ssla_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    stub_key;
    logic [LIB_IN_W-1:0] library_id;
    logic [FN_W-1:0]     function_id;

    modport source (output valid, output stub_key, output library_id,
                    output function_id, input ready);
    modport sink (input valid, input stub_key, input library_id,
                  input function_id, output ready);
endinterface

interface ssla_rsp_if import ssla_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

[sv/ssla_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`default_nettype none

module ssla_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[sv/ssla_seq.sv]
// Scan sequencer: walks the used slots one read per cycle through the
// shared key comparator and decides reuse, allocation or full.
// Depends on ssla_pkg and ssla_if.
`default_nettype none

module ssla_seq import ssla_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    ssla_req_if.sink              i_req,
    input  wire logic [KEY_W-1:0] i_rd_stub,
    input  wire logic             i_out_free,
    output t_ram_cmd              o_ram,
    output t_result               o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [KEY_W-1:0]    r_key;
    logic [LIB_BITS-1:0] r_lib;
    logic [FN_W-1:0]     r_fn;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_addr;
    logic                r_pend;
    logic [IDX_W-1:0]    r_cmp_idx;
    t_status             r_status;
    logic [IDX_W-1:0]    r_index;

    logic rd_more;
    logic hit;
    logic tbl_full;

    // The single comparator checks the slot read in the previous cycle.
    assign rd_more  = (r_addr < r_used);
    assign hit      = r_pend && (i_rd_stub == r_key);
    assign tbl_full = (r_used == CNT_W'(TABLE_DEPTH));

    // No request is taken while reset is held.
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);

    assign o_ram.rd_addr = r_addr[IDX_W-1:0];
    assign o_ram.wr_en   = (r_state == S_DONE) && i_out_free && (r_status != ST_FULL);
    assign o_ram.wr_addr = r_index;
    assign o_ram.wr_data = {r_key, r_lib, r_fn};

    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.index  = r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_key   <= i_req.stub_key;
                        r_lib   <= i_req.library_id[LIB_BITS-1:0];
                        r_fn    <= i_req.function_id;
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend    <= rd_more;
                    r_cmp_idx <= r_addr[IDX_W-1:0];
                    if (rd_more) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (hit) begin
                        r_status <= ST_REUSED;
                        r_index  <= r_cmp_idx;
                        r_state  <= S_DONE;
                    end else if (!rd_more && !r_pend) begin
                        if (tbl_full) begin
                            r_status <= ST_FULL;
                            r_index  <= '0;
                        end else begin
                            r_status <= ST_NEW;
                            r_index  <= r_used[IDX_W-1:0];
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        if (r_status == ST_NEW) begin
                            r_used <= r_used + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_DEPTH))
        else $error("slot count exceeds table depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_FULL) |-> (o_res.index == '0 && tbl_full))
        else $error("full reported while a slot is free");

    a_alloc_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && i_out_free && o_res.status == ST_NEW)
        |=> (r_used == CNT_W'($past(r_used) + 1'b1)))
        else $error("allocation did not advance the slot count");

    a_reuse_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_REUSED) |-> (CNT_W'(o_res.index) < r_used))
        else $error("reused slot lies beyond the used slots");

endmodule

`default_nettype wire

[sv/stub_slot_lookup_or_allocate.sv]
// Top level of the stub slot lookup-or-allocate table.
// Depends on ssla_pkg, ssla_if, ssla_ram and ssla_seq.
//
// This block keeps a table of 2048 slots, each holding a stub address, a
// library id and a function id, filled from slot 0 upward. A request transfer
// carries a stub address, library id and function id. The block scans the
// slots in use in ascending order, reading one slot per cycle from the single
// read port of the slot memory and comparing its stub address against the
// request. On the first match it overwrites that slot's library and function
// ids and answers with status 0 (reused) and the slot number. With no match it
// appends the request in the next free slot and answers with status 1 (new);
// when all slots are taken it changes nothing and answers with status 2 (full)
// and slot number zero. The request channel is not ready while a scan
// runs. A finished response sits in an output register, so the next request
// can be taken while the response transfer still waits. No clearing pass is
// needed after reset: the slot count resets to zero and only written slots
// are ever searched.
`default_nettype none

module stub_slot_lookup_or_allocate import ssla_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ssla_req_if.sink  i_req,
    ssla_rsp_if.source o_rsp
);

    t_ram_cmd          ram_cmd;
    t_result           res;
    logic [ENTRY_W-1:0] rd_entry;
    logic              out_free;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_index;

    // The output register can take a new response when empty or when the
    // current one transfers in this cycle.
    assign out_free = !r_out_valid || o_rsp.ready;

    // One wide slot memory; only the stub address part is used for the scan,
    // the library and function ids are stored alongside it.
    ssla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_cmd.wr_en),
        .i_wr_addr (ram_cmd.wr_addr),
        .i_wr_data (ram_cmd.wr_data),
        .i_rd_addr (ram_cmd.rd_addr),
        .o_rd_data (rd_entry)
    );

    ssla_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_rd_stub  (rd_entry[ENTRY_W-1 -: KEY_W]),
        .i_out_free (out_free),
        .o_ram      (ram_cmd),
        .o_res      (res)
    );

    // Response output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res.valid) begin
            r_out_status <= res.status;
            r_out_index  <= SLOT_W'(res.index);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_index = r_out_index;

endmodule

`default_nettype wire
